// ===== sv/person_follow_controller_unit_macros.svh =====
// Assertion macros shared by the person-follow controller RTL.
`ifndef PERSON_FOLLOW_CONTROLLER_UNIT_MACROS_SVH
`define PERSON_FOLLOW_CONTROLLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define PFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define PFC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define PFC_ASSERT(lbl, prop, msg)
`define PFC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== sv/pfc_pkg.sv =====
// Shared widths, codes and arithmetic helpers of the person-follow controller.
package pfc_pkg;

    // Field widths
    localparam int W_FUNC  = 2;
    localparam int W_CONF  = 10;
    localparam int W_SPEED = 14;
    localparam int W_DIST  = 15;
    localparam int W_LAT   = 15;
    localparam int W_OANG  = 13;
    localparam int W_LIN   = 14;
    localparam int W_ANG   = 16;
    localparam int W_MODE  = 3;
    localparam int W_HOLD  = 16;
    localparam int W_AGE   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RND_W  = 22;
    localparam int QUOT_W = 14;
    localparam int DVD_W  = 31;
    localparam int DVS_W  = 16;

    // Target staleness limit in ticks
    localparam logic [W_AGE-1:0] TARGET_TIMEOUT_TICKS = 8'd5;

    // Trigger codes
    localparam logic [W_FUNC-1:0] FUNC_NONE   = 2'd0;
    localparam logic [W_FUNC-1:0] FUNC_START  = 2'd1;
    localparam logic [W_FUNC-1:0] FUNC_CANCEL = 2'd2;

    // Mode codes
    localparam logic [W_MODE-1:0] MODE_IDLE   = 3'd0;
    localparam logic [W_MODE-1:0] MODE_FOLLOW = 3'd1;
    localparam logic [W_MODE-1:0] MODE_HOLD   = 3'd2;
    localparam logic [W_MODE-1:0] MODE_STOP   = 3'd3;
    localparam logic [W_MODE-1:0] MODE_LOST   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_RADIUS  = 3'd7;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Round a Q12 product to nearest, ties away from zero
    function automatic logic signed [RND_W-1:0] round_q12(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sum;
        logic [RND_W-1:0]  q;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        sum = mag + PROD_W'(2048);
        q   = sum[RND_W+11:12];
        return p[PROD_W-1] ? $signed(RND_W'(-q)) : $signed(q);
    endfunction

endpackage

// ===== sv/pfc_if.sv =====
// Request and result channels of the person-follow controller.
interface pfc_in_if;
    import pfc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [W_FUNC-1:0]          func;
    logic                       target_fresh;
    logic                       target_ok;
    logic [W_CONF-1:0]          target_confidence;
    logic signed [W_SPEED-1:0]  target_speed_mmps;
    logic [W_DIST-1:0]          target_distance_mm;
    logic signed [W_LAT-1:0]    target_lateral_mm;
    logic                       obstacle_ok;
    logic [W_DIST-1:0]          obstacle_distance_mm;
    logic signed [W_OANG-1:0]   obstacle_angle_mrad;

    modport source (
        output valid, func, target_fresh, target_ok, target_confidence,
               target_speed_mmps, target_distance_mm, target_lateral_mm,
               obstacle_ok, obstacle_distance_mm, obstacle_angle_mrad,
        input  ready
    );
    modport sink (
        input  valid, func, target_fresh, target_ok, target_confidence,
               target_speed_mmps, target_distance_mm, target_lateral_mm,
               obstacle_ok, obstacle_distance_mm, obstacle_angle_mrad,
        output ready
    );
endinterface

interface pfc_out_if;
    import pfc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [W_LIN-1:0]    linear_mmps;
    logic signed [W_ANG-1:0]    angular_mradps;
    logic [W_MODE-1:0]          mode;
    logic                       engaged;

    modport source (
        output valid, linear_mmps, angular_mradps, mode, engaged,
        input  ready
    );
    modport sink (
        input  valid, linear_mmps, angular_mradps, mode, engaged,
        output ready
    );
endinterface

// ===== sv/pfc_mul.sv =====
// Shared signed multiplier with a registered product.
module pfc_mul (
    input  logic                               i_clk,
    input  logic signed [pfc_pkg::MUL_W-1:0]   i_a,
    input  logic signed [pfc_pkg::MUL_W-1:0]   i_b,
    output logic signed [pfc_pkg::PROD_W-1:0]  o_prod
);
    import pfc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    // Form the product of the operands the sequencer selects
    assign n_prod = i_a * i_b;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;
endmodule

// ===== sv/pfc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the obstacle repulsion term.
`include "person_follow_controller_unit_macros.svh"
module pfc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pfc_pkg::DVD_W-1:0]         i_dividend,
    input  logic [pfc_pkg::DVS_W-1:0]         i_divisor,
    output logic [pfc_pkg::QUOT_W-1:0]        o_quot,
    output pfc_pkg::t_div_status              o_stat
);
    import pfc_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DVS_W-1:0]    r_rem;
    logic [QUOT_W-1:0]   r_quo;
    logic [DVS_W-1:0]    r_div;
    logic                n_busy;
    logic                n_done;
    logic [CNT_W-1:0]    n_cnt;
    logic [DVS_W-1:0]    n_rem;
    logic [QUOT_W-1:0]   n_quo;
    logic [DVS_W-1:0]    n_div;
    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      diff;
    logic                ge;

    // Shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[QUOT_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    // Sequence the iterations
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QUOT_W - 1);
            n_rem  = i_dividend[DVD_W-2:QUOT_W];
            n_quo  = i_dividend[QUOT_W-1:0];
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_quo = {r_quo[QUOT_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_quot      = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `PFC_ASSERT(a_start_when_free, i_start |-> !r_busy, "divider restarted while busy")
    `PFC_ASSERT(a_last_step_done, r_busy && (r_cnt == '0) && !i_start |=> !r_busy && r_done, "divider failed to finish")
    `PFC_ASSERT_NEVER(a_rem_bound, r_busy && (r_rem >= r_div), "partial remainder reached divisor")
endmodule

// ===== sv/person_follow_controller_unit.sv =====
// Person-follow controller: tick sequencer, mode state and shared arithmetic.
// One request is one control tick. It is taken when i_in.ready is high, which is only
// while the sequencer is idle. A tick that yields no command goes from the decide state
// back to idle. A cancel, target-lost, hold or stop command goes from the decide state
// to the emit state; a follow command passes the multiply steps MLIN, MANG and MREP,
// which use the shared multiplier in turn, then, when obstacle repulsion acts, DSTART
// and DWAIT for the divider of the repulsion term, and then SUM and EMIT. The block is
// ready for the next request in the cycle its command becomes valid. A finished command
// waits in the output register, and the next request is taken meanwhile; a further
// command then waits in the sequencer, with the input stalled, until the output register
// is free. Configuration registers are written at any edge with i_cfg_we high.
`include "person_follow_controller_unit_macros.svh"
module person_follow_controller_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    pfc_in_if.sink                                i_in,
    pfc_out_if.source                             o_out
);
    import pfc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_MLIN   = 9'b000000100,
        S_MANG   = 9'b000001000,
        S_MREP   = 9'b000010000,
        S_DSTART = 9'b000100000,
        S_DWAIT  = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    // Configuration
    logic [14:0] r_cfg_fdist;
    logic [12:0] r_cfg_maxs;
    logic [15:0] r_cfg_dgain;
    logic [15:0] r_cfg_tgain;
    logic [9:0]  r_cfg_conf;
    logic [15:0] r_cfg_hold;
    logic [13:0] r_cfg_rgain;
    logic [14:0] r_cfg_rrad;

    // Control state
    t_state              r_state, n_state;
    logic                r_engaged, n_engaged;
    logic [W_MODE-1:0]   r_mode, n_mode;
    logic [W_HOLD-1:0]   r_hold, n_hold;
    logic [W_AGE-1:0]    r_age, n_age;
    logic                r_rep_on, n_rep_on;
    logic                r_out_valid, n_out_valid;

    // Captured request
    logic [W_FUNC-1:0]          r_func, n_func;
    logic                       r_tok, n_tok;
    logic [W_CONF-1:0]          r_conf, n_conf;
    logic signed [W_SPEED-1:0]  r_speed, n_speed;
    logic [W_DIST-1:0]          r_dist, n_dist;
    logic signed [W_LAT-1:0]    r_lat, n_lat;
    logic                       r_ook, n_ook;
    logic [W_DIST-1:0]          r_odist, n_odist;
    logic signed [W_OANG-1:0]   r_oang, n_oang;

    // Working values and result
    logic signed [RND_W-1:0]    r_lin, n_lin;
    logic signed [RND_W-1:0]    r_ang, n_ang;
    logic signed [W_LIN-1:0]    r_res_lin, n_res_lin;
    logic signed [W_ANG-1:0]    r_res_ang, n_res_ang;
    logic [W_MODE-1:0]          r_res_mode, n_res_mode;
    logic                       r_res_eng, n_res_eng;
    logic signed [W_LIN-1:0]    r_out_lin, n_out_lin;
    logic signed [W_ANG-1:0]    r_out_ang, n_out_ang;
    logic [W_MODE-1:0]          r_out_mode, n_out_mode;
    logic                       r_out_eng, n_out_eng;

    // Decision terms
    logic                       is_start;
    logic                       is_cancel;
    logic                       eng_eff;
    logic [W_MODE-1:0]          mode_eff;
    logic                       lost;
    logic                       slow;
    logic [W_HOLD-1:0]          hold_next;
    logic                       hold_over;
    logic                       rep_on;
    logic signed [15:0]         err;
    logic [12:0]                lim;
    logic signed [RND_W-1:0]    lim_s;
    logic signed [RND_W-1:0]    rnd;
    logic signed [RND_W:0]      ang_sum;
    logic signed [RND_W:0]      rep_v;
    logic                       out_free;

    // Shared units
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic                       div_start;
    logic [DVD_W-1:0]           dividend;
    logic [QUOT_W-1:0]          quot;
    t_div_status                div_stat;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fdist <= 15'd1500;
            r_cfg_maxs  <= 13'd800;
            r_cfg_dgain <= 16'd2048;
            r_cfg_tgain <= 16'd3277;
            r_cfg_conf  <= 10'd400;
            r_cfg_hold  <= 16'd200;
            r_cfg_rgain <= 14'd500;
            r_cfg_rrad  <= 15'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOLLOW_DIST: r_cfg_fdist <= i_cfg_data[14:0];
                CFG_MAX_SPEED:   r_cfg_maxs  <= i_cfg_data[12:0];
                CFG_DIST_GAIN:   r_cfg_dgain <= i_cfg_data;
                CFG_TURN_GAIN:   r_cfg_tgain <= i_cfg_data;
                CFG_CONF_LIMIT:  r_cfg_conf  <= i_cfg_data[9:0];
                CFG_HOLD_LIMIT:  r_cfg_hold  <= i_cfg_data;
                CFG_REP_GAIN:    r_cfg_rgain <= i_cfg_data[13:0];
                CFG_REP_RADIUS:  r_cfg_rrad  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Decide the tick from the captured request
    assign is_start  = (r_func == FUNC_START);
    assign is_cancel = (r_func == FUNC_CANCEL);
    assign eng_eff   = r_engaged | is_start;
    assign mode_eff  = is_start ? MODE_FOLLOW : r_mode;
    assign lost      = !r_tok || (r_age > TARGET_TIMEOUT_TICKS) || (r_conf < r_cfg_conf);
    assign slow      = (r_speed > -14'sd50) && (r_speed < 14'sd50);
    assign hold_next = (mode_eff != MODE_HOLD) ? '0 :
                       (r_hold == '1) ? r_hold : r_hold + W_HOLD'(1);
    assign hold_over = (hold_next > r_cfg_hold);
    assign rep_on    = r_ook && (r_odist < r_cfg_rrad) && (r_odist > 15'd10);

    // Distance error and speed limit
    assign err   = $signed({1'b0, r_dist}) - $signed({1'b0, r_cfg_fdist});
    assign lim   = (r_cfg_maxs < 13'd5000) ? r_cfg_maxs : 13'd5000;
    assign lim_s = $signed({{(RND_W-13){1'b0}}, lim});

    // Select multiplier operands by step
    always_comb begin
        unique case (r_state)
            S_MLIN: begin
                mul_a = MUL_W'(err);
                mul_b = $signed({1'b0, r_cfg_dgain});
            end
            S_MANG: begin
                mul_a = MUL_W'(r_lat);
                mul_b = $signed({1'b0, r_cfg_tgain});
            end
            default: begin
                mul_a = $signed({2'b00, r_cfg_rrad - r_odist});
                mul_b = $signed({3'b000, r_cfg_rgain});
            end
        endcase
    end

    pfc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Repulsion quotient: (2 * num + r) / (2 * r)
    assign div_start = (r_state == S_DSTART);
    assign dividend  = {prod[DVD_W-2:0], 1'b0} + {{(DVD_W-15){1'b0}}, r_cfg_rrad};

    pfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  ({r_cfg_rrad, 1'b0}),
        .o_quot     (quot),
        .o_stat     (div_stat)
    );

    assign rnd      = round_q12(prod);
    assign rep_v    = r_rep_on ? $signed({{(RND_W+1-QUOT_W){1'b0}}, quot}) : '0;
    assign ang_sum  = r_oang[W_OANG-1] ? (RND_W+1)'(r_ang) + rep_v
                                       : (RND_W+1)'(r_ang) - rep_v;
    assign out_free = !r_out_valid || o_out.ready;

    // Sequence one tick
    always_comb begin
        n_state     = r_state;
        n_engaged   = r_engaged;
        n_mode      = r_mode;
        n_hold      = r_hold;
        n_age       = r_age;
        n_rep_on    = r_rep_on;
        n_func      = r_func;
        n_tok       = r_tok;
        n_conf      = r_conf;
        n_speed     = r_speed;
        n_dist      = r_dist;
        n_lat       = r_lat;
        n_ook       = r_ook;
        n_odist     = r_odist;
        n_oang      = r_oang;
        n_lin       = r_lin;
        n_ang       = r_ang;
        n_res_lin   = r_res_lin;
        n_res_ang   = r_res_ang;
        n_res_mode  = r_res_mode;
        n_res_eng   = r_res_eng;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_lin   = r_out_lin;
        n_out_ang   = r_out_ang;
        n_out_mode  = r_out_mode;
        n_out_eng   = r_out_eng;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func  = i_in.func;
                    n_tok   = i_in.target_ok;
                    n_conf  = i_in.target_confidence;
                    n_speed = i_in.target_speed_mmps;
                    n_dist  = i_in.target_distance_mm;
                    n_lat   = i_in.target_lateral_mm;
                    n_ook   = i_in.obstacle_ok;
                    n_odist = i_in.obstacle_distance_mm;
                    n_oang  = i_in.obstacle_angle_mrad;
                    // Age the target reading every tick
                    if (i_in.target_fresh) begin
                        n_age = '0;
                    end else if (r_age != '1) begin
                        n_age = r_age + W_AGE'(1);
                    end
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res_lin = '0;
                n_res_ang = '0;
                n_rep_on  = rep_on;
                priority if (is_cancel) begin
                    n_engaged  = 1'b0;
                    n_mode     = MODE_STOP;
                    n_res_mode = MODE_STOP;
                    n_res_eng  = 1'b0;
                    n_state    = S_EMIT;
                end else if (!eng_eff) begin
                    n_state = S_IDLE;
                end else if (lost) begin
                    n_engaged  = 1'b0;
                    n_mode     = MODE_LOST;
                    n_res_mode = MODE_LOST;
                    n_res_eng  = 1'b0;
                    n_state    = S_EMIT;
                end else if (slow) begin
                    n_hold = hold_next;
                    if (hold_over) begin
                        n_engaged  = 1'b0;
                        n_mode     = MODE_STOP;
                        n_res_mode = MODE_STOP;
                        n_res_eng  = 1'b0;
                    end else begin
                        n_engaged  = 1'b1;
                        n_mode     = MODE_HOLD;
                        n_res_mode = MODE_HOLD;
                        n_res_eng  = 1'b1;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_engaged = 1'b1;
                    n_mode    = MODE_FOLLOW;
                    n_state   = S_MLIN;
                end
            end
            S_MLIN: begin
                n_state = S_MANG;
            end
            S_MANG: begin
                n_lin   = rnd;
                n_state = S_MREP;
            end
            S_MREP: begin
                n_ang = rnd;
                // Clamp linear speed to the limit
                if (r_lin > lim_s) begin
                    n_lin = lim_s;
                end else if (r_lin < -lim_s) begin
                    n_lin = -lim_s;
                end
                n_state = r_rep_on ? S_DSTART : S_SUM;
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_stat.done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_res_lin = r_lin[W_LIN-1:0];
                if (ang_sum > (RND_W+1)'(32767)) begin
                    n_res_ang = 16'sd32767;
                end else if (ang_sum < -(RND_W+1)'(32767)) begin
                    n_res_ang = -16'sd32767;
                end else begin
                    n_res_ang = ang_sum[W_ANG-1:0];
                end
                n_res_mode = r_mode;
                n_res_eng  = r_engaged;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_lin   = r_res_lin;
                    n_out_ang   = r_res_ang;
                    n_out_mode  = r_res_mode;
                    n_out_eng   = r_res_eng;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_engaged   <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_hold      <= '0;
            r_age       <= '1;
            r_rep_on    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_engaged   <= n_engaged;
            r_mode      <= n_mode;
            r_hold      <= n_hold;
            r_age       <= n_age;
            r_rep_on    <= n_rep_on;
            r_out_valid <= n_out_valid;
        end
    end

    // Advance payload registers
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_tok      <= n_tok;
        r_conf     <= n_conf;
        r_speed    <= n_speed;
        r_dist     <= n_dist;
        r_lat      <= n_lat;
        r_ook      <= n_ook;
        r_odist    <= n_odist;
        r_oang     <= n_oang;
        r_lin      <= n_lin;
        r_ang      <= n_ang;
        r_res_lin  <= n_res_lin;
        r_res_ang  <= n_res_ang;
        r_res_mode <= n_res_mode;
        r_res_eng  <= n_res_eng;
        r_out_lin  <= n_out_lin;
        r_out_ang  <= n_out_ang;
        r_out_mode <= n_out_mode;
        r_out_eng  <= n_out_eng;
    end

    // Drive the channels
    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.linear_mmps    = r_out_lin;
    assign o_out.angular_mradps = r_out_ang;
    assign o_out.mode           = r_out_mode;
    assign o_out.engaged        = r_out_eng;

    `PFC_ASSERT(a_engaged_mode, r_engaged |-> (r_mode == MODE_FOLLOW) || (r_mode == MODE_HOLD), "engaged outside follow or hold")
    `PFC_ASSERT(a_lin_range, r_out_valid |-> (r_out_lin <= 14'sd5000) && (r_out_lin >= -14'sd5000), "linear command beyond limit")
    `PFC_ASSERT_NEVER(a_hold_zero, r_out_valid && (r_out_mode != MODE_FOLLOW) && ((r_out_lin != '0) || (r_out_ang != '0)), "motion outside follow mode")
endmodule

// ===== bench/pfc_checker.sv =====
// Command predictor and scoreboard for the person-follow controller bench.
module pfc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pfc_in_if                              i_req,
    pfc_out_if                             i_cmd,
    output int                             o_errors,
    output int                             o_pending
);
    import pfc_pkg::*;

    // One control tick as seen on the request channel
    typedef struct packed {
        logic [W_FUNC-1:0]  func;
        logic               fresh;
        logic               ok;
        logic [W_CONF-1:0]  conf;
        logic [W_SPEED-1:0] speed;
        logic [W_DIST-1:0]  distance;
        logic [W_LAT-1:0]   lateral;
        logic               obs_ok;
        logic [W_DIST-1:0]  obs_dist;
        logic [W_OANG-1:0]  obs_ang;
    } t_tick;

    // One motion command
    typedef struct packed {
        logic [W_LIN-1:0]  linear;
        logic [W_ANG-1:0]  angular;
        logic [W_MODE-1:0] mode;
        logic              engaged;
    } t_motion_cmd;

    // Register copies
    logic [14:0] follow_dist;
    logic [12:0] max_speed;
    logic [15:0] dist_gain;
    logic [15:0] turn_gain;
    logic [9:0]  conf_limit;
    logic [15:0] hold_limit;
    logic [13:0] rep_gain;
    logic [14:0] rep_radius;

    // Controller state copies
    logic              engaged;
    logic [W_MODE-1:0] mode;
    logic [W_HOLD-1:0] hold_count;
    logic [W_AGE-1:0]  target_age;

    t_motion_cmd cmd_queue[$];
    int          error_count;

    // Count one mismatch and describe it on one line
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Interpret the low w bits as two's complement
    function automatic longint as_signed(input logic [15:0] bits, input int w);
        longint v;
        v = bits & ((64'd1 << w) - 1);
        if (bits[w-1])
            v = v - (longint'(1) << w);
        return v;
    endfunction

    // Round a Q12 product to nearest, halves away from zero
    function automatic longint nearest_q12(input longint p);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + 2048) >>> 12;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint limit_mag(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Advance the controller by one tick and queue the command it gives
    task automatic run_tick(input t_tick t);
        longint lim, err, lin, ang, r, od, num, rep;
        bit     emit_cmd;
        t_motion_cmd c;
        emit_cmd = 1'b0;
        lin = 0;
        ang = 0;
        if (t.fresh)
            target_age = '0;
        else if (target_age != 8'hFF)
            target_age = target_age + 1'b1;

        if (t.func == FUNC_CANCEL) begin
            engaged  = 1'b0;
            mode     = MODE_STOP;
            emit_cmd = 1'b1;
        end else begin
            if (t.func == FUNC_START) begin
                engaged = 1'b1;
                mode    = MODE_FOLLOW;
            end
            if (engaged) begin
                emit_cmd = 1'b1;
                if (!t.ok || target_age > TARGET_TIMEOUT_TICKS || t.conf < conf_limit) begin
                    engaged = 1'b0;
                    mode    = MODE_LOST;
                end else if (as_signed(t.speed, W_SPEED) > -50 &&
                             as_signed(t.speed, W_SPEED) < 50) begin
                    // Person nearly still: hold, then stop once the limit is passed
                    if (mode != MODE_HOLD) begin
                        mode       = MODE_HOLD;
                        hold_count = '0;
                    end else if (hold_count != 16'hFFFF) begin
                        hold_count = hold_count + 1'b1;
                    end
                    if (hold_count > hold_limit) begin
                        engaged = 1'b0;
                        mode    = MODE_STOP;
                    end
                end else begin
                    mode = MODE_FOLLOW;
                    lim  = (max_speed < 13'd5000) ? longint'(max_speed) : 5000;
                    err  = longint'(t.distance) - longint'(follow_dist);
                    lin  = limit_mag(nearest_q12(longint'(dist_gain) * err), lim);
                    ang  = nearest_q12(longint'(turn_gain) * as_signed(t.lateral, W_LAT));
                    r    = rep_radius;
                    od   = t.obs_dist;
                    // Steer away from a close obstacle
                    if (t.obs_ok && od < r && od > 10 && r > 0) begin
                        num = longint'(rep_gain) * (r - od);
                        rep = (2 * num + r) / (2 * r);
                        if (as_signed(t.obs_ang, W_OANG) >= 0)
                            ang = ang - rep;
                        else
                            ang = ang + rep;
                    end
                    ang = limit_mag(ang, 32767);
                end
            end
        end

        if (emit_cmd) begin
            c.linear  = lin[W_LIN-1:0];
            c.angular = ang[W_ANG-1:0];
            c.mode    = mode;
            c.engaged = engaged;
            cmd_queue.push_back(c);
        end
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Compare one delivered command with the oldest prediction
    task automatic check_cmd(input t_motion_cmd got);
        t_motion_cmd want;
        if (cmd_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected command lin=%0d ang=%0d mode=%0d eng=%0d",
                                      as_signed(got.linear, W_LIN),
                                      as_signed(got.angular, W_ANG), got.mode, got.engaged));
        end else begin
            want = cmd_queue.pop_front();
            check_field("linear_mmps", as_signed(got.linear, W_LIN),
                        as_signed(want.linear, W_LIN));
            check_field("angular_mradps", as_signed(got.angular, W_ANG),
                        as_signed(want.angular, W_ANG));
            check_field("mode", got.mode, want.mode);
            check_field("engaged", got.engaged, want.engaged);
        end
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_FOLLOW_DIST: follow_dist = data[14:0];
            CFG_MAX_SPEED:   max_speed   = data[12:0];
            CFG_DIST_GAIN:   dist_gain   = data;
            CFG_TURN_GAIN:   turn_gain   = data;
            CFG_CONF_LIMIT:  conf_limit  = data[9:0];
            CFG_HOLD_LIMIT:  hold_limit  = data;
            CFG_REP_GAIN:    rep_gain    = data[13:0];
            CFG_REP_RADIUS:  rep_radius  = data[14:0];
            default: ;
        endcase
    endtask

    // Watch configuration, results and requests at each rising edge
    always @(posedge i_clk) begin
        t_tick       t;
        t_motion_cmd got;
        if (!i_rst_n) begin
            follow_dist = 15'd1500;
            max_speed   = 13'd800;
            dist_gain   = 16'd2048;
            turn_gain   = 16'd3277;
            conf_limit  = 10'd400;
            hold_limit  = 16'd200;
            rep_gain    = 14'd500;
            rep_radius  = 15'd1000;
            engaged     = 1'b0;
            mode        = MODE_IDLE;
            hold_count  = '0;
            target_age  = 8'hFF;
            cmd_queue.delete();
        end else begin
            if (i_cfg_we)
                apply_write(i_cfg_idx, i_cfg_data);
            if (i_cmd.valid && i_cmd.ready) begin
                got.linear  = i_cmd.linear_mmps;
                got.angular = i_cmd.angular_mradps;
                got.mode    = i_cmd.mode;
                got.engaged = i_cmd.engaged;
                check_cmd(got);
            end
            if (i_req.valid && i_req.ready) begin
                t.func     = i_req.func;
                t.fresh    = i_req.target_fresh;
                t.ok       = i_req.target_ok;
                t.conf     = i_req.target_confidence;
                t.speed    = i_req.target_speed_mmps;
                t.distance = i_req.target_distance_mm;
                t.lateral  = i_req.target_lateral_mm;
                t.obs_ok   = i_req.obstacle_ok;
                t.obs_dist = i_req.obstacle_distance_mm;
                t.obs_ang  = i_req.obstacle_angle_mrad;
                run_tick(t);
            end
        end
        o_errors  <= error_count;
        o_pending <= cmd_queue.size();
    end

endmodule

// ===== bench/tb_person_follow_controller_unit.sv =====
// Top-level bench for the person-follow controller: stimulus, flow control and verdict.
module tb_person_follow_controller_unit;
    import pfc_pkg::*;

    // Trigger code the block treats as no trigger
    localparam logic [W_FUNC-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pfc_in_if  req_bus();
    pfc_out_if cmd_bus();

    int errors;
    int pending;
    int ticks_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int holdoff_asks;
    int conf_floor;
    bit slow_run;
    int stale_left;

    person_follow_controller_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_bus),
        .o_out      (cmd_bus)
    );

    pfc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .i_cmd      (cmd_bus),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Drop the run if it hangs
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Command receiver: random stalls, plus long hold-offs on request
    initial begin
        int seen;
        int hold_left;
        seen = 0;
        hold_left = 0;
        cmd_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_asks != seen) begin
                seen = holdoff_asks;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                cmd_bus.ready <= 1'b0;
            end else begin
                cmd_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one tick, after an optional gap, and hold it until taken
    task automatic drive_tick(input logic [W_FUNC-1:0] fn,
                              input int fresh, ok, conf, speed, tgt_dist, lat,
                              o_ok, o_dist, o_ang);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid                <= 1'b1;
        req_bus.func                 <= fn;
        req_bus.target_fresh         <= 1'(fresh);
        req_bus.target_ok            <= 1'(ok);
        req_bus.target_confidence    <= W_CONF'(conf);
        req_bus.target_speed_mmps    <= W_SPEED'(speed);
        req_bus.target_distance_mm   <= W_DIST'(tgt_dist);
        req_bus.target_lateral_mm    <= W_LAT'(lat);
        req_bus.obstacle_ok          <= 1'(o_ok);
        req_bus.obstacle_distance_mm <= W_DIST'(o_dist);
        req_bus.obstacle_angle_mrad  <= W_OANG'(o_ang);
        do @(posedge i_clk); while (!req_bus.ready);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Random tick content shaped to keep a follow session alive
    task automatic random_tick(input logic [W_FUNC-1:0] fn);
        int fresh, ok, conf, spd, tgt_dist, lat, o_ok, o_dist, o_ang;
        if ($urandom_range(7) == 0)
            slow_run = !slow_run;
        if (stale_left == 0 && $urandom_range(29) == 0)
            stale_left = $urandom_range(3, 8);
        fresh = (stale_left == 0) && ($urandom_range(19) != 0);
        if (stale_left > 0)
            stale_left--;
        ok   = ($urandom_range(39) != 0);
        conf = ($urandom_range(9) != 0) ? $urandom_range(conf_floor, 1000)
                                        : $urandom_range(1023);
        if (slow_run)
            spd = $urandom_range(98) - 49;
        else if ($urandom_range(19) == 0)
            spd = $urandom_range(16383);
        else
            spd = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(50, 5000));
        tgt_dist = ($urandom_range(19) == 0) ? $urandom_range(32767) : $urandom_range(20000);
        lat      = ($urandom_range(19) == 0) ? $urandom_range(32767)
                                             : $urandom_range(20000) - 10000;
        o_ok   = ($urandom_range(9) < 7);
        if ($urandom_range(1))
            o_dist = $urandom_range(3000);
        else
            o_dist = ($urandom_range(19) == 0) ? $urandom_range(32767) : $urandom_range(20000);
        o_ang  = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(6284) - 3142;
        drive_tick(fn, fresh, ok, conf, spd, tgt_dist, lat, o_ok, o_dist, o_ang);
    endtask

    // Start, run a stretch of ticks with the odd trigger, maybe cancel
    task automatic follow_session();
        int len;
        logic [W_FUNC-1:0] fn;
        slow_run = 1'b0;
        stale_left = 0;
        random_tick(FUNC_START);
        len = $urandom_range(1, 40);
        repeat (len) begin
            case ($urandom_range(59))
                0: fn = FUNC_CANCEL;
                1: fn = FUNC_START;
                2: fn = FUNC_UNUSED;
                default: fn = FUNC_NONE;
            endcase
            random_tick(fn);
        end
        if ($urandom_range(1))
            random_tick(FUNC_CANCEL);
    endtask

    // Mix sessions with raw noise until enough further ticks are sent
    task automatic run_traffic(input int ticks);
        int goal;
        goal = ticks_sent + ticks;
        while (ticks_sent < goal) begin
            if ($urandom_range(9) == 0)
                drive_tick(W_FUNC'($urandom_range(3)), $urandom_range(1), $urandom_range(1),
                           $urandom_range(1023), $urandom_range(16383), $urandom_range(32767),
                           $urandom_range(32767), $urandom_range(1), $urandom_range(32767),
                           $urandom_range(8191));
            else
                follow_session();
        end
    endtask

    // Stop offering and wait until every predicted command is out
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic load_setting(input logic [15:0] fd, ms, dg, tg, cl, hl, rg, rr);
        write_reg(CFG_FOLLOW_DIST, fd);
        write_reg(CFG_MAX_SPEED, ms);
        write_reg(CFG_DIST_GAIN, dg);
        write_reg(CFG_TURN_GAIN, tg);
        write_reg(CFG_CONF_LIMIT, cl);
        write_reg(CFG_HOLD_LIMIT, hl);
        write_reg(CFG_REP_GAIN, rg);
        write_reg(CFG_REP_RADIUS, rr);
        i_cfg_we <= 1'b0;
        conf_floor = (cl[9:0] > 10'd1000) ? 1000 : int'(cl[9:0]);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        req_bus.valid = 1'b0;
        req_bus.func  = '0;
        req_bus.target_fresh         = 1'b0;
        req_bus.target_ok            = 1'b0;
        req_bus.target_confidence    = '0;
        req_bus.target_speed_mmps    = '0;
        req_bus.target_distance_mm   = '0;
        req_bus.target_lateral_mm    = '0;
        req_bus.obstacle_ok          = 1'b0;
        req_bus.obstacle_distance_mm = '0;
        req_bus.obstacle_angle_mrad  = '0;
        holdoff_asks  = 0;
        ticks_sent    = 0;
        conf_floor    = 400;
        slow_run      = 1'b0;
        stale_left    = 0;
        send_idle_pct = 17;
        recv_idle_pct = 49;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks at reset settings
        // idle tick, cancel while idle, unused trigger
        drive_tick(FUNC_NONE, 1, 1, 500, 300, 2000, 0, 0, 0, 0);
        drive_tick(FUNC_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drive_tick(FUNC_UNUSED, 1, 1, 500, 300, 2000, 0, 0, 0, 0);
        // start at field extremes, speed clamp, repulsion both signs
        drive_tick(FUNC_START, 1, 1, 1000, 5000, 20000, 10000, 1, 500, 3142);
        drive_tick(FUNC_NONE, 1, 1, 400, -5000, 0, -10000, 1, 11, -3142);
        drive_tick(FUNC_NONE, 1, 1, 999, 200, 1500, 1, 1, 10, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, -200, 1501, -1, 1, 999, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, 200, 1499, 2, 1, 1000, -1);
        // hold band edges
        drive_tick(FUNC_NONE, 1, 1, 700, 49, 3000, 100, 0, 0, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, -49, 3000, 100, 0, 0, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, 0, 3000, 100, 0, 0, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, 50, 3000, 100, 0, 0, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, -50, 3000, 100, 0, 0, 0);
        // low confidence, then age out without fresh readings
        drive_tick(FUNC_NONE, 1, 1, 399, 300, 3000, 0, 0, 0, 0);
        drive_tick(FUNC_START, 0, 1, 700, 300, 2500, 0, 0, 0, 0);
        repeat (4) drive_tick(FUNC_NONE, 0, 1, 700, 300, 2500, 0, 0, 0, 0);
        drive_tick(FUNC_NONE, 0, 1, 700, 300, 2500, 0, 0, 0, 0);
        // invalid target, cancel while engaged, then ignored tick
        drive_tick(FUNC_START, 1, 0, 700, 300, 2500, 0, 0, 0, 0);
        drive_tick(FUNC_START, 1, 1, 700, 300, 2500, 0, 0, 0, 0);
        drive_tick(FUNC_CANCEL, 1, 1, 700, 300, 2500, 0, 0, 0, 0);
        drive_tick(FUNC_NONE, 1, 1, 700, 300, 2500, 0, 0, 0, 0);

        // Long receiver hold-off while requests keep coming, then a full drain
        holdoff_asks++;
        run_traffic(55);
        settle();
        run_traffic(130);

        // Minimum gains, confidence limit at the top of its range: targets below 1023 lost
        settle();
        load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'h03FF, 16'd0, 16'd0, 16'd1);
        run_traffic(75);

        send_idle_pct = 49;
        recv_idle_pct = 17;
        // Top of every range
        settle();
        load_setting(16'd20000, 16'd5000, 16'hFFFF, 16'hFFFF, 16'd1000, 16'hFFFF,
                     16'd10000, 16'd20000);
        run_traffic(205);

        // Bits beyond range, zero radius, zero confidence limit, stop on the tick after hold is entered
        settle();
        load_setting(16'hFFFF, 16'hFFFF, 16'd4096, 16'd8192, 16'd0, 16'd0,
                     16'hFFFF, 16'h8000);
        run_traffic(215);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        load_setting(16'd1000, 16'd1200, 16'd12000, 16'd2000, 16'd300, 16'd1,
                     16'd2500, 16'd3000);
        run_traffic(225);

        settle();
        load_setting(16'd1500, 16'd800, 16'd2048, 16'd3277, 16'd400, 16'd10,
                     16'd500, 16'd1000);
        run_traffic(225);

        settle();
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_if.sv
sv/pfc_mul.sv
sv/pfc_div.sv
sv/person_follow_controller_unit.sv
bench/pfc_checker.sv
bench/tb_person_follow_controller_unit.sv
